// ----- hw/rtl/palette_hash_indexer_core_defines.svh -----
// Assertion helpers used by the palette indexer datapath RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef PALETTE_HASH_INDEXER_CORE_DEFINES_SVH
`define PALETTE_HASH_INDEXER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define PHI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("palette indexer check failed");
`define PHI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("palette indexer check failed");
`else
`define PHI_ASSERT(lbl, clk, rstn, prop)
`define PHI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- hw/rtl/phi_pkg.sv -----
`timescale 1ns / 1ps
package phi_pkg;

  localparam int unsigned PIXEL_W    = 32;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned IDX_W      = 9;
  localparam int unsigned ENTRY_W    = IDX_W + COLOR_W;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - (2 * IDX_W + COLOR_W + 3);

  localparam logic [PIXEL_W-1:0] MARKER_PIXEL = 32'hFFFE_FEFE;
  localparam logic [IDX_W-1:0]   FIRST_INDEX  = 9'd1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef struct packed {
    logic capture;
    logic flags_reset;
    logic clr_step;
    logic mod_start;
    logic pos_load;
    logic rd_probe;
    logic rd_slot;
    logic probe_adv;
    logic ins_write;
    logic set_found;
    logic set_slot;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic mod_busy;
    logic clr_last;
    logic entry_empty;
    logic color_match;
    logic step_zero;
    logic full;
    logic slot_in_range;
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/phi_ram.sv -----
`timescale 1ns / 1ps
module phi_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 1021
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/phi_home_mod.sv -----
`timescale 1ns / 1ps
module phi_home_mod #(
  parameter int unsigned MODULUS = 1021
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [phi_pkg::PIXEL_W-1:0]  operand_i,
  output logic                         busy_o,
  output logic [$clog2(MODULUS)-1:0]   rem_o
);
  import phi_pkg::*;

  localparam int unsigned RW  = $clog2(MODULUS);
  localparam int unsigned RCW = PIXEL_W + 1 - RW;
  localparam int unsigned PW  = PIXEL_W + RCW;
  // floor(2^32 / M): the quotient estimate falls at most one short
  localparam longint unsigned RECIP_L = (64'd1 << PIXEL_W) / MODULUS;
  localparam logic [RCW-1:0]  RECIP   = RCW'(RECIP_L);
  localparam logic [RW:0]     MOD_X   = (RW + 1)'(MODULUS);

  logic [2:0]         stage_q;
  logic [PIXEL_W-1:0] opnd_q;
  logic [RW:0]        quot_q;
  logic [RW:0]        red_q;
  logic [RW-1:0]      rem_q;

  logic [PW-1:0]      prod;
  logic [RW:0]        qm;
  logic [RW:0]        red_d;
  logic [RW-1:0]      rem_d;

  // Estimate the quotient, subtract its multiple, then correct once.
  // Only the low bits of the remainder matter, as it stays below 2M.
  assign prod  = {{RCW{1'b0}}, opnd_q} * {{PIXEL_W{1'b0}}, RECIP};
  assign qm    = quot_q * MOD_X;
  assign red_d = opnd_q[RW:0] - qm;
  assign rem_d = (red_q >= MOD_X) ? RW'(red_q - MOD_X) : red_q[RW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= {stage_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      opnd_q <= operand_i;
    end
    if (stage_q[0]) begin
      quot_q <= prod[PIXEL_W+RW:PIXEL_W];
    end
    if (stage_q[1]) begin
      red_q <= red_d;
    end
    if (stage_q[2]) begin
      rem_q <= rem_d;
    end
  end

  assign busy_o = |stage_q;
  assign rem_o  = rem_q;

endmodule

// ----- hw/rtl/phi_dpath.sv -----
`timescale 1ns / 1ps
`include "palette_hash_indexer_core_defines.svh"
module phi_dpath #(
  parameter int unsigned TABLE_SLOTS   = 1021,
  parameter int unsigned PALETTE_LIMIT = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  phi_pkg::cmd_t                 cmd_i,
  output phi_pkg::status_t              sts_o,
  input  logic [phi_pkg::IN_DATA_W-1:0] in_data_i,
  input  logic [phi_pkg::OP_W-1:0]      in_op_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [phi_pkg::OUT_DATA_W-1:0] out_data_o
);
  import phi_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_SLOTS);
  localparam int unsigned SX = (AW > SLOT_W) ? AW : SLOT_W;
  localparam logic [AW:0]      SLOTS_X   = (AW + 1)'(TABLE_SLOTS);
  localparam logic [AW-1:0]    LAST_SLOT = AW'(TABLE_SLOTS - 1);
  localparam logic [IDX_W-1:0] LIMIT     = IDX_W'(PALETTE_LIMIT);

  logic [PIXEL_W-1:0] in_pixel;
  logic [SLOT_W-1:0]  in_slot;

  op_e                op_q;
  logic [PIXEL_W-1:0] pixel_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [AW-1:0]      pos_q;
  logic [AW-1:0]      step_q;
  logic [AW-1:0]      clr_cnt_q;
  logic [IDX_W-1:0]   next_index_q;
  logic               no_marker_q;
  logic [IDX_W-1:0]   idx_q;
  logic               hit_q;
  logic [COLOR_W-1:0] scol_q;
  logic               out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic [AW-1:0]      home_rem;
  logic               mod_busy;
  logic [ENTRY_W-1:0] rdata;
  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata;

  logic [SX-1:0]      slot_x;
  logic [AW:0]        pos_sum;
  logic [AW:0]        step_sum;
  logic [AW-1:0]      pos_nxt;
  logic [AW-1:0]      step_nxt;
  logic               full;
  logic               out_free;

  assign in_pixel = in_data_i[PIXEL_W-1:0];
  assign in_slot  = in_data_i[PIXEL_W+SLOT_W-1:PIXEL_W];

  phi_home_mod #(
    .MODULUS (TABLE_SLOTS)
  ) u_home_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.mod_start),
    .operand_i (in_pixel),
    .busy_o    (mod_busy),
    .rem_o     (home_rem)
  );

  phi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  assign slot_x    = SX'(slot_q);
  assign ram_re    = cmd_i.rd_probe | cmd_i.rd_slot;
  assign ram_raddr = cmd_i.rd_slot ? slot_x[AW-1:0] : pos_q;
  assign ram_we    = cmd_i.clr_step | cmd_i.ins_write;
  assign ram_waddr = cmd_i.clr_step ? clr_cnt_q : pos_q;
  assign ram_wdata = cmd_i.clr_step ? '0 : {next_index_q, pixel_q[COLOR_W-1:0]};

  // Both slot and step stay below the table size, so one subtract wraps them
  assign pos_sum  = {1'b0, pos_q} + {1'b0, step_q};
  assign step_sum = {1'b0, step_q} + (AW + 1)'(2);
  assign pos_nxt  = (pos_sum >= SLOTS_X) ? AW'(pos_sum - SLOTS_X) : pos_sum[AW-1:0];
  assign step_nxt = (step_sum >= SLOTS_X) ? AW'(step_sum - SLOTS_X) : step_sum[AW-1:0];

  assign full     = next_index_q > LIMIT;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.op            = op_q;
    sts_o.mod_busy      = mod_busy;
    sts_o.clr_last      = clr_cnt_q == LAST_SLOT;
    sts_o.entry_empty   = rdata == '0;
    sts_o.color_match   = rdata[COLOR_W-1:0] == pixel_q[COLOR_W-1:0];
    sts_o.step_zero     = step_q == '0;
    sts_o.full          = full;
    sts_o.slot_in_range = slot_x < SX'(TABLE_SLOTS);
    sts_o.out_free      = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_index_q <= FIRST_INDEX;
      no_marker_q  <= 1'b1;
      clr_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.flags_reset) begin
        next_index_q <= FIRST_INDEX;
        no_marker_q  <= 1'b1;
      end else begin
        if (cmd_i.capture && (op_e'(in_op_i) == OP_INSERT) && (in_pixel == MARKER_PIXEL)) begin
          no_marker_q <= 1'b0;
        end
        if (cmd_i.ins_write) begin
          next_index_q <= next_index_q + IDX_W'(1);
        end
      end
      if (cmd_i.clr_step) begin
        clr_cnt_q <= (clr_cnt_q == LAST_SLOT) ? '0 : clr_cnt_q + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_e'(in_op_i);
      pixel_q <= in_pixel;
      slot_q  <= in_slot;
      idx_q   <= '0;
      hit_q   <= 1'b0;
      scol_q  <= '0;
    end
    if (cmd_i.pos_load) begin
      pos_q  <= home_rem;
      step_q <= AW'(1);
    end else if (cmd_i.probe_adv) begin
      pos_q  <= pos_nxt;
      step_q <= step_nxt;
    end
    if (cmd_i.ins_write) begin
      idx_q <= next_index_q;
      hit_q <= 1'b1;
    end else if (cmd_i.set_found) begin
      idx_q <= rdata[ENTRY_W-1:COLOR_W];
      hit_q <= 1'b1;
    end else if (cmd_i.set_slot) begin
      idx_q  <= rdata[ENTRY_W-1:COLOR_W];
      hit_q  <= 1'b1;
      scol_q <= rdata[COLOR_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_data_q <= {{OUT_PAD_W{1'b0}}, no_marker_q, full, next_index_q, scol_q, hit_q, idx_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `PHI_ASSERT(a_index_range, clk_i, rst_ni, (next_index_q >= FIRST_INDEX) && (next_index_q <= LIMIT + IDX_W'(1)))
  `PHI_ASSERT(a_no_insert_when_full, clk_i, rst_ni, cmd_i.ins_write |-> !full)
  `PHI_ASSERT(a_probe_in_table, clk_i, rst_ni, cmd_i.rd_probe |-> (pos_q <= LAST_SLOT) && (step_q <= LAST_SLOT))
  `PHI_ASSERT_NEXT(a_insert_counts, clk_i, rst_ni, cmd_i.ins_write, next_index_q == $past(next_index_q) + IDX_W'(1))
  `PHI_ASSERT(a_load_only_when_free, clk_i, rst_ni, cmd_i.out_load |-> out_free)

endmodule

// ----- hw/rtl/phi_ctrl.sv -----
`timescale 1ns / 1ps
module phi_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  phi_pkg::op_e     in_op_i,
  output logic             in_ready_o,
  input  phi_pkg::status_t sts_i,
  output phi_pkg::cmd_t    cmd_o
);
  import phi_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_SLOT_RD,
    S_SLOT_CHK,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   reply_q, reply_d;

  always_comb begin
    state_d    = state_q;
    reply_d    = reply_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          // the sweep after reset answers nothing; a clear request does
          state_d = reply_q ? S_DONE : S_IDLE;
          reply_d = 1'b0;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (in_op_i)
            OP_CLEAR: begin
              cmd_o.flags_reset = 1'b1;
              reply_d           = 1'b1;
              state_d           = S_CLEAR;
            end
            OP_INSERT: begin
              if (sts_i.full) begin
                state_d = S_DONE;
              end else begin
                cmd_o.mod_start = 1'b1;
                state_d         = S_HOME;
              end
            end
            OP_LOOKUP: begin
              cmd_o.mod_start = 1'b1;
              state_d         = S_HOME;
            end
            OP_READ: begin
              state_d = S_SLOT_RD;
            end
          endcase
        end
      end
      S_HOME: begin
        if (!sts_i.mod_busy) begin
          cmd_o.pos_load = 1'b1;
          state_d        = S_PROBE_RD;
        end
      end
      S_PROBE_RD: begin
        cmd_o.rd_probe = 1'b1;
        state_d        = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        priority if (sts_i.entry_empty) begin
          if (sts_i.op == OP_INSERT) begin
            cmd_o.ins_write = 1'b1;
          end
          state_d = S_DONE;
        end else if (sts_i.color_match) begin
          cmd_o.set_found = 1'b1;
          state_d         = S_DONE;
        end else if (sts_i.step_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.probe_adv = 1'b1;
          state_d         = S_PROBE_RD;
        end
      end
      S_SLOT_RD: begin
        cmd_o.rd_slot = 1'b1;
        state_d       = S_SLOT_CHK;
      end
      S_SLOT_CHK: begin
        if (sts_i.slot_in_range && !sts_i.entry_empty) begin
          cmd_o.set_slot = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      reply_q <= 1'b0;
    end else begin
      state_q <= state_d;
      reply_q <= reply_d;
    end
  end

endmodule

// ----- hw/rtl/palette_hash_indexer_core.sv -----
`timescale 1ns / 1ps
// Insert and lookup probe the table from the home slot, one RAM read and one compare per
// probe; the home slot comes from the reciprocal modulo unit. Read slot reads a single
// slot. Clear sweeps the whole table to empty.
// One request at a time; the next is taken while a finished result waits on the output.
// Reset (rst_ni low, asynchronous) restores the counters and then sweeps the table to
// empty, one slot a cycle, before the first request is taken.
module palette_hash_indexer_core #(
  parameter int unsigned TABLE_SLOTS   = 1021,
  parameter int unsigned PALETTE_LIMIT = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // pixel [31:0], slot [41:32], zero [47:42]
  input  logic [phi_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // opcode [1:0]
  input  logic [phi_pkg::OP_W-1:0]       s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // color_index [8:0], hit [9], slot_color [33:10], next_index [42:34],
  // overflow [43], transparent_free [44], zero [47:45]
  output logic [phi_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import phi_pkg::*;

  cmd_t    cmd;
  status_t sts;

  phi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (op_e'(s_axis_tuser)),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  phi_dpath #(
    .TABLE_SLOTS   (TABLE_SLOTS),
    .PALETTE_LIMIT (PALETTE_LIMIT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_op_i     (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
